// ===== rtl/tknm_pkg.sv =====
// Shared types and constants for the top-k nearest-candidate merge block.
`default_nettype none

package tknm_pkg;

   // Field widths of one candidate and one reported neighbour.
   localparam int DIST_W  = 32;
   localparam int LABEL_W = 64;
   localparam int RANK_W  = 5;
   localparam int COUNT_W = 6;

   // Neighbour count after reset.
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(10);

   // One store entry as it travels between neighboring cells.
   typedef struct packed {
      logic               valid;
      logic [DIST_W-1:0]  distance;
      logic [LABEL_W-1:0] label;
   } tknm_entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic drain;
   } tknm_ctl_type;

   // True when pair (da, la) is strictly nearer than pair (db, lb).
   function automatic logic pair_less(input logic [DIST_W-1:0] da,
                                      input logic [LABEL_W-1:0] la,
                                      input logic [DIST_W-1:0] db,
                                      input logic [LABEL_W-1:0] lb);
      pair_less = (da < db) || ((da == db) && (la < lb));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tknm_cell.sv =====
// One cell of the sorted insertion chain: holds one entry and trades it with its neighbors.
`default_nettype none

module tknm_cell
   import tknm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tknm_ctl_type       ctl,
   input  wire logic               enable,
   input  wire logic [DIST_W-1:0]  cand_dist,
   input  wire logic [LABEL_W-1:0] cand_label,
   input  wire tknm_entry_type     prev_entry,
   input  wire logic               prev_less,
   input  wire tknm_entry_type     next_entry,
   output tknm_entry_type          entry,
   output logic                    less
);

   logic               valid_ff, valid_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [LABEL_W-1:0] label_ff, label_in;
   logic               live;

   // An entry beyond the current neighbour count no longer counts.
   assign live = valid_ff && enable;

   // The candidate goes in front of this entry, or into this empty cell.
   assign less = !live || pair_less(cand_dist, cand_label, dist_ff, label_ff);

   assign entry = '{valid: live, distance: dist_ff, label: label_ff};

   // Insert pushes entries one cell farther; drain pulls them one cell nearer.
   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      label_in = label_ff;
      if (ctl.insert) begin
         if (!enable) begin
            valid_in = 1'b0;
         end else if (prev_less) begin
            valid_in = prev_entry.valid;
            dist_in  = prev_entry.distance;
            label_in = prev_entry.label;
         end else if (less) begin
            valid_in = 1'b1;
            dist_in  = cand_dist;
            label_in = cand_label;
         end else begin
            valid_in = live;
         end
      end else if (ctl.drain) begin
         valid_in = next_entry.valid;
         dist_in  = next_entry.distance;
         label_in = next_entry.label;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff  <= dist_in;
      label_ff <= label_in;
   end

endmodule

`default_nettype wire

// ===== rtl/top_k_nearest_merge.sv =====
// Top level of the top-k nearest-candidate merge: control, registers and the cell chain.
//
// Use: a candidate beat (distance, label, final mark) is taken at a rising edge
// with req_start high and busy low. The chain of MAX_NEIGHBOURS cells keeps the
// k nearest candidates sorted nearest first; every cell compares the candidate
// with its own entry in the same cycle, so a candidate that is not final is
// merged in its accept cycle and the next one may follow directly.
// A final candidate is merged in its accept cycle; then busy rises and the store
// drains one entry per cycle through cell 0. Each neighbour appears on the rsp_
// ports for one cycle with rsp_strobe high, rank 0 first, rsp_run_end on the
// last. Each result is registered from cell 0 into the rsp_ registers, and busy
// falls as the last entry is taken from cell 0. With k set to 0, a final
// candidate gives no results and holds busy for one cycle.
// The receiver cannot stall; results are never held back.
// csr_wr_en writes k (count_ff); k above MAX_NEIGHBOURS acts as the depth.
// Write it only while idle. Reset empties the store and sets k to 10.
`default_nettype none

module top_k_nearest_merge
   import tknm_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_start,
   output logic                    busy,
   input  wire logic [DIST_W-1:0]  req_candidate_distance,
   input  wire logic [LABEL_W-1:0] req_candidate_label,
   input  wire logic               req_final_candidate,
   output logic                    rsp_strobe,
   output logic [DIST_W-1:0]       rsp_nearest_distance,
   output logic [LABEL_W-1:0]      rsp_nearest_label,
   output logic [RANK_W-1:0]       rsp_neighbour_rank,
   output logic                    rsp_run_end,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type          state_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               strobe_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [LABEL_W-1:0] label_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic               run_end_ff;

   logic               accept;
   tknm_ctl_type       ctl;
   tknm_entry_type     entries [MAX_NEIGHBOURS+1];
   logic               less_vec [MAX_NEIGHBOURS];

   assign busy   = (state_ff == ST_DRAIN);
   assign accept = req_start && !busy;

   // Command to the chain: insert on an accepted beat, shift down while draining.
   assign ctl.insert = accept;
   assign ctl.drain  = busy && entries[0].valid;

   // Nothing lies past the last cell.
   assign entries[MAX_NEIGHBOURS] = '{valid: 1'b0, distance: '0, label: '0};

   // Row of cells; cell g looks at cell g-1 for inserts and cell g+1 for drains.
   for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
      tknm_entry_type prev_entry;
      logic           prev_less;
      logic           enable;

      if (g == 0) begin : g_first
         assign prev_entry = '{valid: 1'b0, distance: '0, label: '0};
         assign prev_less  = 1'b0;
      end else begin : g_rest
         assign prev_entry = entries[g-1];
         assign prev_less  = less_vec[g-1];
      end

      assign enable = (int'(count_ff) > g);

      tknm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .enable     (enable),
         .cand_dist  (req_candidate_distance),
         .cand_label (req_candidate_label),
         .prev_entry (prev_entry),
         .prev_less  (prev_less),
         .next_entry (entries[g+1]),
         .entry      (entries[g]),
         .less       (less_vec[g])
      );
   end

   // Neighbour count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Drain sequencer and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         rank_ff   <= '0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_final_candidate) begin
                  state_ff <= ST_DRAIN;
                  rank_ff  <= '0;
               end
            end
            ST_DRAIN: begin
               if (entries[0].valid) begin
                  strobe_ff <= 1'b1;
                  if (strobe_ff) begin
                     rank_ff <= rank_ff + RANK_W'(1);
                  end
                  if (!entries[1].valid) begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      dist_ff    <= entries[0].distance;
      label_ff   <= entries[0].label;
      run_end_ff <= !entries[1].valid;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_nearest_distance = dist_ff;
   assign rsp_nearest_label    = label_ff;
   assign rsp_neighbour_rank   = rank_ff;
   assign rsp_run_end          = run_end_ff;

endmodule

`default_nettype wire

// ===== rtl/tknm_checker.sv =====
// Port-level assertions for the top-k nearest-candidate merge, bound to the top level.
`default_nettype none

module tknm_checker
   import tknm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_start,
   input wire logic              busy,
   input wire logic              req_final_candidate,
   input wire logic              rsp_strobe,
   input wire logic [RANK_W-1:0] rsp_neighbour_rank,
   input wire logic              rsp_run_end
);

   // A final candidate always starts a drain.
   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy && req_final_candidate |=> busy)
      else $error("final candidate did not start a drain");

   // A beat is only produced by a drain that was running the cycle before.
   a_beat_from_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a drain");

   // A run has no gaps: a beat that is not the last is followed by another.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_run_end |=> rsp_strobe)
      else $error("gap inside a result run");

   // Ranks count up by one inside a run.
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_run_end |=>
         rsp_neighbour_rank == $past(rsp_neighbour_rank) + RANK_W'(1))
      else $error("rank did not step by one");

endmodule

bind top_k_nearest_merge tknm_checker u_tknm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_start           (req_start),
   .busy                (busy),
   .req_final_candidate (req_final_candidate),
   .rsp_strobe          (rsp_strobe),
   .rsp_neighbour_rank  (rsp_neighbour_rank),
   .rsp_run_end         (rsp_run_end)
);

`default_nettype wire
